### design/mlp_pkg.sv
// shared types and constants of the mlp forward pass block
package mlp_pkg;

  localparam logic [1:0] ActWeight = 2'd0;
  localparam logic [1:0] ActBias   = 2'd1;
  localparam logic [1:0] ActInput  = 2'd2;
  localparam logic [1:0] ActUnused = 2'd3;

  localparam logic [1:0] CfgInputCount  = 2'd0;
  localparam logic [1:0] CfgHiddenLayer = 2'd1;
  localparam logic [1:0] CfgHiddenNode  = 2'd2;
  localparam logic [1:0] CfgOutputCount = 2'd3;

  localparam int unsigned ResultLimit = 16;
  localparam int unsigned AccW        = 40;
  localparam int unsigned MagW        = 41;
  localparam int unsigned NumW        = 56;
  localparam int unsigned DenW        = 44;
  localparam int unsigned QW          = 13;
  localparam int unsigned DivLastBit  = 12;
  localparam int unsigned DrainCycles = 2;
  localparam logic [MagW:0] AccOne    = 42'd16777216;

  typedef struct packed {
    logic w_we;
    logic b_we;
    logic a_we;
    logic a_from_y;
    logic bias_rd;
    logic mac_rd;
    logic div_start;
  } mlp_cmd_t;

  typedef struct packed {
    logic div_busy;
    logic div_done;
  } mlp_sts_t;

endpackage

### design/mlp_if.sv
// stream interfaces for input items and result items
interface mlp_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [10:0] item_index;
  logic signed [15:0] item_value;
  logic        input_last;
  modport source (output valid, action, item_index, item_value, input_last, input ready);
  modport sink (input valid, action, item_index, item_value, input_last, output ready);
endinterface

interface mlp_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  output_index;
  logic [12:0] output_value;
  logic        result_last;
  modport source (output valid, output_index, output_value, result_last, input ready);
  modport sink (input valid, output_index, output_value, result_last, output ready);
endinterface

### design/mlp_ram.sv
// generic single write port ram with registered read
module mlp_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;
endmodule

### design/mlp_datapath.sv
// stores, multiply-accumulate and sigmoid divider
module mlp_datapath #(
  parameter int unsigned ND  = 96,
  parameter int unsigned WD  = 1280,
  parameter int unsigned NAW = 7,
  parameter int unsigned WAW = 11
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  mlp_pkg::mlp_cmd_t     cmd_i,
  output mlp_pkg::mlp_sts_t     sts_o,
  input  logic signed [15:0]    item_value_i,
  input  logic [WAW-1:0]        w_waddr_i,
  input  logic [WAW-1:0]        w_raddr_i,
  input  logic [NAW-1:0]        b_waddr_i,
  input  logic [NAW-1:0]        b_raddr_i,
  input  logic [NAW-1:0]        a_waddr_i,
  input  logic [NAW-1:0]        a_raddr_i,
  output logic [mlp_pkg::QW-1:0] y_o
);
  import mlp_pkg::*;

  logic [15:0] w_rdata, b_rdata, a_rdata, a_wdata;
  logic bias_pend_q, mac_pend_q, prod_v_q;
  logic signed [31:0] prod_q;
  logic [AccW-1:0] acc_q;
  logic [NumW-1:0] num_q, trial;
  logic [DenW-1:0] den_q;
  logic [QW-1:0] quo_q;
  logic [3:0] bit_q;
  logic busy_q, done_q;
  logic neg;
  logic [MagW-1:0] mag;
  logic [MagW:0] dsum;
  logic [MagW+1:0] base;

  assign a_wdata = cmd_i.a_from_y ? {3'b000, quo_q} : item_value_i;

  mlp_ram #(.WIDTH(16), .DEPTH(WD)) u_wram (
    .clk_i, .we_i(cmd_i.w_we), .waddr_i(w_waddr_i), .wdata_i(item_value_i),
    .raddr_i(w_raddr_i), .rdata_o(w_rdata)
  );
  mlp_ram #(.WIDTH(16), .DEPTH(ND)) u_bram (
    .clk_i, .we_i(cmd_i.b_we), .waddr_i(b_waddr_i), .wdata_i(item_value_i),
    .raddr_i(b_raddr_i), .rdata_o(b_rdata)
  );
  mlp_ram #(.WIDTH(16), .DEPTH(ND)) u_aram (
    .clk_i, .we_i(cmd_i.a_we), .waddr_i(a_waddr_i), .wdata_i(a_wdata),
    .raddr_i(a_raddr_i), .rdata_o(a_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bias_pend_q <= 1'b0;
      mac_pend_q  <= 1'b0;
      prod_v_q    <= 1'b0;
    end else begin
      bias_pend_q <= cmd_i.bias_rd;
      mac_pend_q  <= cmd_i.mac_rd;
      prod_v_q    <= mac_pend_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mac_pend_q) begin
      prod_q <= $signed(a_rdata) * $signed(w_rdata);
    end
    priority if (bias_pend_q) begin
      acc_q <= {{(AccW-28){b_rdata[15]}}, b_rdata, 12'h000};
    end else if (prod_v_q) begin
      acc_q <= acc_q + {{(AccW-32){prod_q[31]}}, prod_q};
    end
  end

  always_comb begin
    neg  = acc_q[AccW-1];
    mag  = neg ? (MagW'(0) - {acc_q[AccW-1], acc_q}) : {1'b0, acc_q};
    dsum = {1'b0, mag} + AccOne;
    base = neg ? {1'b0, AccOne} : ({1'b0, mag, 1'b0} + {1'b0, AccOne});
    trial = NumW'(den_q) << bit_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      bit_q  <= 4'd0;
    end else begin
      done_q <= 1'b0;
      if (cmd_i.div_start) begin
        busy_q <= 1'b1;
        bit_q  <= 4'(DivLastBit);
      end else if (busy_q) begin
        if (bit_q == 4'd0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          bit_q <= bit_q - 4'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) begin
      num_q <= (NumW'(base) << 12) + NumW'(dsum);
      den_q <= {DenW'(dsum)} << 1;
      quo_q <= '0;
    end else if (busy_q) begin
      if (num_q >= trial) begin
        num_q <= num_q - trial;
        quo_q[bit_q] <= 1'b1;
      end
    end
  end

  assign sts_o.div_busy = busy_q;
  assign sts_o.div_done = done_q;
  assign y_o = quo_q;
endmodule

### design/mlp_ctrl.sv
// sequencer over loads, layers, nodes and source terms
module mlp_ctrl #(
  parameter int unsigned MI  = 16,
  parameter int unsigned ML  = 4,
  parameter int unsigned MH  = 16,
  parameter int unsigned MO  = 16,
  parameter int unsigned ND  = 96,
  parameter int unsigned WD  = 1280,
  parameter int unsigned NAW = 7,
  parameter int unsigned WAW = 11,
  parameter int unsigned LW  = 3
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [1:0]        in_action_i,
  input  logic [10:0]       in_index_i,
  input  logic              in_last_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [3:0]        out_index_o,
  output logic              out_last_o,
  input  logic [4:0]        cfg_input_count_i,
  input  logic [2:0]        cfg_hidden_layer_count_i,
  input  logic [4:0]        cfg_hidden_node_count_i,
  input  logic [4:0]        cfg_output_count_i,
  output mlp_pkg::mlp_cmd_t cmd_o,
  input  mlp_pkg::mlp_sts_t sts_i,
  output logic [WAW-1:0]    w_waddr_o,
  output logic [WAW-1:0]    w_raddr_o,
  output logic [NAW-1:0]    b_waddr_o,
  output logic [NAW-1:0]    b_raddr_o,
  output logic [NAW-1:0]    a_waddr_o,
  output logic [NAW-1:0]    a_raddr_o
);
  import mlp_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_BIAS  = 3'd1;
  localparam logic [2:0] S_MAC   = 3'd2;
  localparam logic [2:0] S_DRAIN = 3'd3;
  localparam logic [2:0] S_DIVS  = 3'd4;
  localparam logic [2:0] S_DIV   = 3'd5;
  localparam logic [2:0] S_STORE = 3'd6;
  localparam logic [2:0] S_OUT   = 3'd7;

  function automatic int unsigned clampc(int unsigned v, int unsigned top);
    int unsigned r;
    r = (v < 1) ? 1 : ((v > top) ? top : v);
    return r;
  endfunction

  logic [2:0] state_q, state_d;
  logic [NAW-1:0] src_q, src_d, lstart_q, lstart_d, dst_q, dst_d;
  logic [NAW-1:0] cnt_q, cnt_d, nodes_q, nodes_d, j_q, j_d, k_q, k_d;
  logic [WAW-1:0] widx_q, widx_d;
  logic [LW-1:0] layer_q, layer_d, nl;
  logic [1:0] drain_q, drain_d;
  logic out_valid_q, out_valid_d, out_last_q, out_last_d;
  logic [3:0] out_index_q, out_index_d;
  logic [NAW-1:0] ni, nh, no;
  logic accept, node_last, out_layer;

  always_comb begin
    ni = NAW'(clampc(32'(cfg_input_count_i), MI));
    nh = NAW'(clampc(32'(cfg_hidden_node_count_i), MH));
    no = NAW'(clampc(clampc(32'(cfg_output_count_i), MO), ResultLimit));
    nl = LW'(clampc(32'(cfg_hidden_layer_count_i), ML));
  end

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign node_last  = (j_q == nodes_q - NAW'(1));
  assign out_layer  = (layer_q == nl);

  always_comb begin
    state_d     = state_q;
    src_d       = src_q;
    lstart_d    = lstart_q;
    dst_d       = dst_q;
    cnt_d       = cnt_q;
    nodes_d     = nodes_q;
    j_d         = j_q;
    k_d         = k_q;
    widx_d      = widx_q;
    layer_d     = layer_q;
    drain_d     = drain_q;
    out_valid_d = out_valid_q;
    out_last_d  = out_last_q;
    out_index_d = out_index_q;
    cmd_o       = '0;
    w_waddr_o   = WAW'(in_index_i);
    b_waddr_o   = NAW'(in_index_i);
    a_waddr_o   = NAW'(in_index_i);
    w_raddr_o   = widx_q;
    b_raddr_o   = dst_q;
    a_raddr_o   = src_q + k_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          cmd_o.w_we = (in_action_i == ActWeight) && (32'(in_index_i) < WD);
          cmd_o.b_we = (in_action_i == ActBias) && (32'(in_index_i) < ND);
          cmd_o.a_we = (in_action_i == ActInput) && (32'(in_index_i) < 32'(ni));
          if (in_action_i == ActInput && in_last_i) begin
            src_d    = '0;
            lstart_d = ni;
            dst_d    = ni;
            cnt_d    = ni;
            nodes_d  = nh;
            j_d      = '0;
            widx_d   = '0;
            layer_d  = '0;
            state_d  = S_BIAS;
          end
        end
      end
      S_BIAS: begin
        cmd_o.bias_rd = 1'b1;
        k_d = '0;
        state_d = S_MAC;
      end
      S_MAC: begin
        cmd_o.mac_rd = 1'b1;
        k_d = k_q + NAW'(1);
        widx_d = widx_q + WAW'(1);
        if (k_q == cnt_q - NAW'(1)) begin
          drain_d = '0;
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        drain_d = drain_q + 2'd1;
        if (drain_q == 2'(DrainCycles - 1)) begin
          state_d = S_DIVS;
        end
      end
      S_DIVS: begin
        cmd_o.div_start = 1'b1;
        state_d = S_DIV;
      end
      S_DIV: begin
        if (sts_i.div_done) begin
          state_d = S_STORE;
        end
      end
      S_STORE: begin
        cmd_o.a_we = 1'b1;
        cmd_o.a_from_y = 1'b1;
        a_waddr_o = dst_q;
        if (out_layer) begin
          out_valid_d = 1'b1;
          out_index_d = 4'(j_q);
          out_last_d  = node_last;
          state_d     = S_OUT;
        end else begin
          dst_d = dst_q + NAW'(1);
          j_d   = j_q + NAW'(1);
          state_d = S_BIAS;
          if (node_last) begin
            j_d      = '0;
            src_d    = lstart_q;
            lstart_d = dst_q + NAW'(1);
            cnt_d    = nh;
            layer_d  = layer_q + LW'(1);
            nodes_d  = (layer_q + LW'(1) == nl) ? no : nh;
          end
        end
      end
      S_OUT: begin
        if (out_ready_i) begin
          out_valid_d = 1'b0;
          dst_d = dst_q + NAW'(1);
          j_d   = j_q + NAW'(1);
          state_d = node_last ? S_IDLE : S_BIAS;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    src_q       <= src_d;
    lstart_q    <= lstart_d;
    dst_q       <= dst_d;
    cnt_q       <= cnt_d;
    nodes_q     <= nodes_d;
    j_q         <= j_d;
    k_q         <= k_d;
    widx_q      <= widx_d;
    layer_q     <= layer_d;
    drain_q     <= drain_d;
    out_last_q  <= out_last_d;
    out_index_q <= out_index_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_index_o = out_index_q;
  assign out_last_o  = out_last_q;
endmodule

### design/mlp_forward_inference.sv
// top level of the mlp forward pass block
// load items (weight, bias, non-final input) start no pass; the block stays ready for the next item
// a pass runs each node in turn through the one shared multiply-accumulate and the 13-step
// sigmoid divider, and each output node also waits out any result stall
// one item at a time: no item is accepted while a pass runs or a result waits
// reset clears control state and sets every config register to 1; stores stay undefined
module mlp_forward_inference #(
  parameter int unsigned MAX_INPUTS        = 16,
  parameter int unsigned MAX_HIDDEN_LAYERS = 4,
  parameter int unsigned MAX_HIDDEN_NODES  = 16,
  parameter int unsigned MAX_OUTPUTS       = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  mlp_in_if.sink      in_i,
  mlp_out_if.source   out_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import mlp_pkg::*;

  localparam int unsigned ND = MAX_INPUTS + MAX_HIDDEN_LAYERS * MAX_HIDDEN_NODES + MAX_OUTPUTS;
  localparam int unsigned WD = MAX_INPUTS * MAX_HIDDEN_NODES
                             + (MAX_HIDDEN_LAYERS - 1) * MAX_HIDDEN_NODES * MAX_HIDDEN_NODES
                             + MAX_HIDDEN_NODES * MAX_OUTPUTS;
  localparam int unsigned NAW = $clog2(ND);
  localparam int unsigned WAW = $clog2(WD);
  localparam int unsigned LW  = $clog2(MAX_HIDDEN_LAYERS + 1);

  logic [4:0] input_count_q, hidden_node_count_q, output_count_q;
  logic [2:0] hidden_layer_count_q;
  logic       cfg_we;
  mlp_cmd_t   cmd;
  mlp_sts_t   sts;
  logic [WAW-1:0] w_waddr, w_raddr;
  logic [NAW-1:0] b_waddr, b_raddr, a_waddr, a_raddr;
  logic [QW-1:0]  y;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      input_count_q        <= 5'd1;
      hidden_layer_count_q <= 3'd1;
      hidden_node_count_q  <= 5'd1;
      output_count_q       <= 5'd1;
    end else if (cfg_we) begin
      unique case (paddr[3:2])
        CfgInputCount:  input_count_q        <= pwdata[4:0];
        CfgHiddenLayer: hidden_layer_count_q <= pwdata[2:0];
        CfgHiddenNode:  hidden_node_count_q  <= pwdata[4:0];
        CfgOutputCount: output_count_q       <= pwdata[4:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      CfgInputCount:  prdata = {27'd0, input_count_q};
      CfgHiddenLayer: prdata = {29'd0, hidden_layer_count_q};
      CfgHiddenNode:  prdata = {27'd0, hidden_node_count_q};
      CfgOutputCount: prdata = {27'd0, output_count_q};
      default:        prdata = '0;
    endcase
  end

  mlp_ctrl #(
    .MI(MAX_INPUTS), .ML(MAX_HIDDEN_LAYERS), .MH(MAX_HIDDEN_NODES), .MO(MAX_OUTPUTS),
    .ND(ND), .WD(WD), .NAW(NAW), .WAW(WAW), .LW(LW)
  ) u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(in_i.valid), .in_ready_o(in_i.ready), .in_action_i(in_i.action),
    .in_index_i(in_i.item_index), .in_last_i(in_i.input_last),
    .out_valid_o(out_o.valid), .out_ready_i(out_o.ready),
    .out_index_o(out_o.output_index), .out_last_o(out_o.result_last),
    .cfg_input_count_i(input_count_q), .cfg_hidden_layer_count_i(hidden_layer_count_q),
    .cfg_hidden_node_count_i(hidden_node_count_q), .cfg_output_count_i(output_count_q),
    .cmd_o(cmd), .sts_i(sts),
    .w_waddr_o(w_waddr), .w_raddr_o(w_raddr), .b_waddr_o(b_waddr), .b_raddr_o(b_raddr),
    .a_waddr_o(a_waddr), .a_raddr_o(a_raddr)
  );

  mlp_datapath #(.ND(ND), .WD(WD), .NAW(NAW), .WAW(WAW)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts), .item_value_i(in_i.item_value),
    .w_waddr_i(w_waddr), .w_raddr_i(w_raddr), .b_waddr_i(b_waddr), .b_raddr_i(b_raddr),
    .a_waddr_i(a_waddr), .a_raddr_i(a_raddr), .y_o(y)
  );

  assign out_o.output_value = y;

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_i.ready && out_o.valid)) else $error("input taken while result pending");
  a_div_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.div_start |-> !sts.div_busy) else $error("divider restarted while busy");
  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.ready && out_o.result_last |=> in_i.ready)
    else $error("not idle after last result");
endmodule

### tb/mlp_checker.sv
// checker: predicts mlp forward pass results and compares them with the result stream
`timescale 1ns / 1ps
module mlp_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  mlp_in_if           in_mon,
  mlp_out_if          out_mon,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          fail_count,
  output int          pending_count
);
  import mlp_pkg::*;

  localparam int unsigned NodeDepth   = 96;
  localparam int unsigned WeightDepth = 1280;

  typedef struct {
    logic [3:0]  node;
    logic [12:0] value;
    logic        last;
  } activation_t;

  activation_t expected_q[$];

  int weight_mem[WeightDepth];
  int bias_mem[NodeDepth];
  int act_mem[NodeDepth];

  logic [4:0] input_count_r;
  logic [2:0] layer_count_r;
  logic [4:0] node_count_r;
  logic [4:0] output_count_r;

  function automatic int unsigned clamp_count(int unsigned v, int unsigned top);
    if (v < 1) return 1;
    return (v > top) ? top : v;
  endfunction

  function automatic int softsign_sigmoid(longint acc);
    longint unsigned s;
    longint unsigned m;
    longint unsigned d;
    s = 64'd16777216;
    if (acc >= 0) begin
      m = acc;
      d = s + m;
      return int'((64'd4096 * (2 * m + s) + d) / (2 * d));
    end else begin
      m = -acc;
      d = s + m;
      return int'((64'd4096 * s + d) / (2 * d));
    end
  endfunction

  function automatic int node_output(int unsigned node, int unsigned src, int unsigned cnt,
                                     inout int unsigned widx);
    longint acc;
    longint a;
    longint w;
    acc = 0;
    if (node < NodeDepth) acc = longint'(bias_mem[node]) * 4096;
    for (int unsigned k = 0; k < cnt; k++) begin
      a = (src + k < NodeDepth) ? act_mem[src + k] : 0;
      w = (widx < WeightDepth) ? weight_mem[widx] : 0;
      acc += a * w;
      widx++;
    end
    return softsign_sigmoid(acc);
  endfunction

  task automatic store_act(int unsigned node, int v);
    if (node < NodeDepth) act_mem[node] = v;
  endtask

  task automatic forward_pass();
    int unsigned ni, nl, nh, no, widx, base, src, dst;
    int y;
    activation_t r;
    ni = clamp_count(32'(input_count_r), 16);
    nl = clamp_count(32'(layer_count_r), 4);
    nh = clamp_count(32'(node_count_r), 16);
    no = clamp_count(clamp_count(32'(output_count_r), 16), ResultLimit);
    widx = 0;
    for (int unsigned j = 0; j < nh; j++)
      store_act(ni + j, node_output(ni + j, 0, ni, widx));
    for (int unsigned h = 1; h < nl; h++) begin
      src = ni + (h - 1) * nh;
      dst = ni + h * nh;
      for (int unsigned j = 0; j < nh; j++)
        store_act(dst + j, node_output(dst + j, src, nh, widx));
    end
    base = ni + nl * nh;
    for (int unsigned j = 0; j < no; j++) begin
      y = node_output(base + j, ni + (nl - 1) * nh, nh, widx);
      store_act(base + j, y);
      r.node  = j[3:0];
      r.value = y[12:0];
      r.last  = (j + 1 == no);
      expected_q.push_back(r);
    end
  endtask

  task automatic report(string what, int got, int want);
    $display("%0t mismatch %s: got %0d expected %0d", $realtime, what, got, want);
    fail_count++;
  endtask

  task automatic take_item();
    int unsigned idx;
    int v;
    idx = 32'(in_mon.item_index);
    v = 32'(in_mon.item_value);
    case (in_mon.action)
      ActWeight: if (idx < WeightDepth) weight_mem[idx] = v;
      ActBias:   if (idx < NodeDepth) bias_mem[idx] = v;
      ActInput: begin
        if (idx < clamp_count(32'(input_count_r), 16)) act_mem[idx] = v;
        if (in_mon.input_last) forward_pass();
      end
      default: ;
    endcase
  endtask

  task automatic check_result();
    activation_t e;
    if (expected_q.size() == 0) begin
      report("unexpected result, output_index", int'(out_mon.output_index), -1);
      return;
    end
    e = expected_q.pop_front();
    if (out_mon.output_index !== e.node)
      report("output_index", int'(out_mon.output_index), int'(e.node));
    if (out_mon.output_value !== e.value)
      report("output_value", int'(out_mon.output_value), int'(e.value));
    if (out_mon.result_last !== e.last)
      report("result_last", int'(out_mon.result_last), int'(e.last));
  endtask

  initial begin
    fail_count = 0;
    pending_count = 0;
    foreach (weight_mem[i]) weight_mem[i] = 0;
    foreach (bias_mem[i]) bias_mem[i] = 0;
    foreach (act_mem[i]) act_mem[i] = 0;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      input_count_r  = 5'd1;
      layer_count_r  = 3'd1;
      node_count_r   = 5'd1;
      output_count_r = 5'd1;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          CfgInputCount:  input_count_r  = pwdata[4:0];
          CfgHiddenLayer: layer_count_r  = pwdata[2:0];
          CfgHiddenNode:  node_count_r   = pwdata[4:0];
          CfgOutputCount: output_count_r = pwdata[4:0];
          default: ;
        endcase
      end
      if (in_mon.valid && in_mon.ready) take_item();
      if (out_mon.valid && out_mon.ready) check_result();
    end
    pending_count = expected_q.size();
  end

endmodule

### tb/tb.sv
// testbench top: stimulus, receiver stalls, configuration writes and verdict
`timescale 1ns / 1ps
module tb;
  import mlp_pkg::*;

  localparam int unsigned CycleLimit = 3000000;
  localparam int          WeightFill = 64;
  localparam int          BiasFill   = 40;

  logic        clk_i;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  int          fail_count;
  int          pending_count;
  int          burst_left;
  bit          hold_req;
  int unsigned cycle_count;

  mlp_in_if  in_ch ();
  mlp_out_if out_ch ();

  mlp_forward_inference i_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_ch),
    .out_o   (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  mlp_checker i_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_mon        (in_ch),
    .out_mon       (out_ch),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .pready        (pready),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk_i);
      cycle_count++;
      if (cycle_count > CycleLimit) begin
        $display("timeout after %0d cycles", cycle_count);
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  // receiver stall pattern
  initial begin
    int mode;
    int run;
    out_ch.ready <= 1'b0;
    forever begin
      mode = $urandom_range(0, 3);
      run = $urandom_range(1, 40);
      repeat (run) begin
        if (hold_req) begin
          out_ch.ready <= 1'b0;
          repeat (600) @(posedge clk_i);
          hold_req = 1'b0;
        end else begin
          case (mode)
            0: out_ch.ready <= 1'b1;
            1: out_ch.ready <= ($urandom_range(0, 1) == 0);
            2: out_ch.ready <= ($urandom_range(0, 3) == 0);
            default: out_ch.ready <= ($urandom_range(0, 7) != 0);
          endcase
          @(posedge clk_i);
        end
      end
    end
  end

  task automatic cfg_write(logic [1:0] idx, logic [31:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic send_item(logic [1:0] act, logic [10:0] idx, logic [15:0] value, logic last);
    in_ch.action     <= act;
    in_ch.item_index <= idx;
    in_ch.item_value <= value;
    in_ch.input_last <= last;
    in_ch.valid      <= 1'b1;
    do @(posedge clk_i); while (!in_ch.ready);
    if (burst_left <= 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
    end else begin
      burst_left--;
    end
  endtask

  task automatic settle();
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending_count != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic set_shape(logic [4:0] ni, logic [2:0] nl, logic [4:0] nh, logic [4:0] no);
    settle();
    cfg_write(CfgInputCount, 32'(ni));
    cfg_write(CfgHiddenLayer, 32'(nl));
    cfg_write(CfgHiddenNode, 32'(nh));
    cfg_write(CfgOutputCount, 32'(no));
  endtask

  function automatic logic [15:0] rand_weight();
    case ($urandom_range(0, 5))
      0: return 16'($urandom());
      1: return 16'h8000;
      2: return 16'h7fff;
      default: return 16'($signed($urandom_range(0, 2047)) - 1024);
    endcase
  endfunction

  task automatic rand_item(bit close_pass);
    int pick;
    pick = $urandom_range(0, 99);
    if (close_pass)
      send_item(ActInput, 11'($urandom_range(0, 31)), 16'($urandom()), 1'b1);
    else if (pick < 40)
      send_item(ActWeight, ($urandom_range(0, 7) == 0) ? 11'($urandom_range(1280, 2047))
                                                        : 11'($urandom_range(0, 1279)),
                rand_weight(), 1'($urandom_range(0, 1)));
    else if (pick < 55)
      send_item(ActBias, ($urandom_range(0, 7) == 0) ? 11'($urandom_range(96, 2047))
                                                      : 11'($urandom_range(0, 95)),
                rand_weight(), 1'($urandom_range(0, 1)));
    else if (pick < 95)
      send_item(ActInput, 11'($urandom_range(0, 31)), 16'($urandom()),
                $urandom_range(0, 5) == 0);
    else
      send_item(ActUnused, 11'($urandom()), 16'($urandom()), 1'($urandom_range(0, 1)));
  endtask

  task automatic rand_phase(int n);
    for (int i = 0; i < n; i++) rand_item(i == n - 1);
  endtask

  initial begin
    rst_ni           <= 1'b0;
    psel             <= 1'b0;
    penable          <= 1'b0;
    pwrite           <= 1'b0;
    paddr            <= '0;
    pwdata           <= '0;
    in_ch.valid      <= 1'b0;
    in_ch.action     <= ActWeight;
    in_ch.item_index <= '0;
    in_ch.item_value <= '0;
    in_ch.input_last <= 1'b0;
    hold_req = 1'b0;
    burst_left = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // fill the entries that every shape below reads
    set_shape(5'd16, 3'd1, 5'd2, 5'd16);
    for (int i = 0; i < WeightFill; i++) send_item(ActWeight, 11'(i), rand_weight(), 1'b0);
    for (int i = 0; i < BiasFill; i++) send_item(ActBias, 11'(i), rand_weight(), 1'b0);
    for (int i = 0; i < 16; i++) send_item(ActInput, 11'(i), 16'($urandom()), 1'b0);

    // directed cases
    send_item(ActInput, 11'd0, 16'h8000, 1'b1);
    send_item(ActInput, 11'd15, 16'h7fff, 1'b1);
    send_item(ActWeight, 11'h7ff, 16'h7fff, 1'b1);
    send_item(ActBias, 11'h7ff, 16'h8000, 1'b1);
    send_item(ActUnused, 11'h7ff, 16'hffff, 1'b1);
    send_item(ActInput, 11'h7ff, 16'h1234, 1'b1);
    send_item(ActBias, 11'd95, 16'h7fff, 1'b0);
    send_item(ActWeight, 11'd1279, 16'h8000, 1'b0);
    send_item(ActInput, 11'd16, 16'hffff, 1'b1);

    set_shape(5'd0, 3'd0, 5'd0, 5'd0);
    send_item(ActInput, 11'd0, 16'h7fff, 1'b1);
    send_item(ActInput, 11'd1, 16'h5555, 1'b1);
    set_shape(5'd31, 3'd7, 5'd1, 5'd31);
    send_item(ActInput, 11'd3, 16'haaaa, 1'b1);
    set_shape(5'd1, 3'd1, 5'd31, 5'd1);
    send_item(ActInput, 11'd0, 16'h4000, 1'b1);
    set_shape(5'd1, 3'd1, 5'd1, 5'd16);
    send_item(ActInput, 11'd0, 16'h0000, 1'b1);

    // random part under several shapes, long receiver hold-off first
    set_shape(5'd16, 3'd1, 5'd2, 5'd16);
    hold_req = 1'b1;
    rand_phase(35);
    set_shape(5'd4, 3'd2, 5'd4, 5'd5);
    rand_phase(30);
    set_shape(5'd1, 3'd1, 5'd1, 5'd1);
    rand_phase(30);
    set_shape(5'($urandom_range(0, 8)), 3'($urandom_range(0, 3)), 5'($urandom_range(0, 3)),
              5'($urandom_range(0, 7)));
    rand_phase(25);
    set_shape(5'd16, 3'd3, 5'd2, 5'd8);
    rand_phase(30);
    settle();
    repeat (100) @(posedge clk_i);

    if (pending_count != 0)
      $display("%0d expected results never arrived", pending_count);
    if (fail_count == 0 && pending_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
